@@ design/rdcp_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB555 display colour pipeline: shared package
// Types and fixed constants used by the pipeline modules.
// ----------------------------------------------------------------------------
package rdcp_pkg;

  localparam int unsigned CH_BITS    = 5;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned ROW_W      = 54;
  localparam int unsigned Q15_W      = 16;
  localparam int unsigned CFG_DATA_W = 54;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PIXEL_W    = 16;

  localparam logic [Q15_W-1:0] ONE_Q15 = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PASSTHROUGH = 3'd0,
    REG_ROW_RED     = 3'd1,
    REG_ROW_GREEN   = 3'd2,
    REG_ROW_BLUE    = 3'd3,
    REG_FLOOR_LIFT  = 3'd4
  } cfg_reg_t;

  // Load enables of the six pipeline stages, a (table read) to f (output).
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
  } pipe_en_t;

endpackage

@@ design/rdcp_decode.sv @@
// ----------------------------------------------------------------------------
// RGB555 display colour pipeline: decode table stage
// Three copies of the 32-entry linear decode table, one per channel, each
// with a registered read. Table loads write all copies at once.
// ----------------------------------------------------------------------------
module rdcp_decode (
  input  logic                                              clk,
  input  rdcp_pkg::pipe_en_t                                en,
  input  logic                                              wr_en,
  input  logic [rdcp_pkg::CH_BITS-1:0]                      wr_index,
  input  logic [rdcp_pkg::Q15_W-1:0]                        wr_value,
  input  logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::CH_BITS-1:0] codes,
  output logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::Q15_W-1:0]   lin
);

  logic [rdcp_pkg::Q15_W-1:0] wr_sat;

  assign wr_sat = (wr_value > rdcp_pkg::ONE_Q15) ? rdcp_pkg::ONE_Q15 : wr_value;

  for (genvar gj = 0; gj < rdcp_pkg::NUM_CH; gj++) begin : g_copy
    logic [rdcp_pkg::Q15_W-1:0] table_r [0:(1 << rdcp_pkg::CH_BITS)-1];
    logic [rdcp_pkg::Q15_W-1:0] lin_r;

    always_ff @(posedge clk) begin
      if (wr_en) begin
        table_r[wr_index] <= wr_sat;
      end
      if (en.a) begin
        lin_r <= table_r[codes[gj]];
      end
    end

    assign lin[gj] = lin_r;
  end

endmodule

@@ design/rdcp_matrix.sv @@
// ----------------------------------------------------------------------------
// RGB555 display colour pipeline: matrix row
// One output row of the 3x3 matrix: three registered products, then the sum
// rounded to Q1.15 and clamped to the range 0 to 1.
// ----------------------------------------------------------------------------
module rdcp_matrix #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                                            clk,
  input  rdcp_pkg::pipe_en_t                              en,
  input  logic [rdcp_pkg::ROW_W-1:0]                      row,
  input  logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::Q15_W-1:0] lin,
  output logic [rdcp_pkg::Q15_W-1:0]                      value
);

  localparam int unsigned PROD_W = rdcp_pkg::COEF_W + rdcp_pkg::Q15_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_nxt [0:rdcp_pkg::NUM_CH-1];
  logic signed [PROD_W-1:0] prod_r   [0:rdcp_pkg::NUM_CH-1];
  logic signed [SUM_W-1:0]  sum;
  logic        [SUM_W-1:0]  rounded;
  logic [rdcp_pkg::Q15_W-1:0] value_nxt;
  logic [rdcp_pkg::Q15_W-1:0] value_r;

  always_comb begin
    for (int j = 0; j < rdcp_pkg::NUM_CH; j++) begin
      prod_nxt[j] = PROD_W'($signed(row[j*rdcp_pkg::COEF_W +: rdcp_pkg::COEF_W]))
                  * PROD_W'($signed({1'b0, lin[j]}));
    end
  end

  always_comb begin
    sum     = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]);
    rounded = SUM_W'(sum + ROUND) >> COEF_FRAC_BITS;
    if (sum <= 0) begin
      value_nxt = '0;
    end else if (rounded > SUM_W'(rdcp_pkg::ONE_Q15)) begin
      value_nxt = rdcp_pkg::ONE_Q15;
    end else begin
      value_nxt = rounded[rdcp_pkg::Q15_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      prod_r <= prod_nxt;
    end
    if (en.c) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

@@ design/rdcp_encode.sv @@
// ----------------------------------------------------------------------------
// RGB555 display colour pipeline: black floor and sRGB encode
// Applies the black-floor lift to one channel, forms the encode index and
// reads the 8-bit code from a constant sRGB encode ROM built at elaboration.
// ----------------------------------------------------------------------------
module rdcp_encode #(
  parameter int unsigned ENCODE_INDEX_BITS = 12
) (
  input  logic                          clk,
  input  rdcp_pkg::pipe_en_t            en,
  input  logic                          passthrough,
  input  logic [rdcp_pkg::Q15_W-1:0]    floor_level,
  input  logic [rdcp_pkg::Q15_W-1:0]    value,
  input  logic [rdcp_pkg::CH_BITS-1:0]  code,
  output logic [7:0]                    enc
);

  localparam int unsigned ROM_DEPTH = (1 << ENCODE_INDEX_BITS) + 1;
  localparam int unsigned IDX_W     = ENCODE_INDEX_BITS + 1;
  localparam int unsigned LIFT_SH   = rdcp_pkg::Q15_W - 1 - ENCODE_INDEX_BITS;
  localparam int unsigned PROD_W    = 2 * rdcp_pkg::Q15_W;
  localparam logic [63:0] ENC_N     = 64'(1) << ENCODE_INDEX_BITS;
  localparam logic [63:0] LIN_DIV   = 64'd10 * ENC_N;

  function automatic logic [255:0] big_pow(input logic [255:0] base, input int unsigned ex);
    logic [255:0] acc;
    acc = 256'd1;
    for (int unsigned t = 0; t < ex; t++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Largest code k whose threshold n^5 * (40k+541)^12 does not exceed
  // i^5 * 10761^12; the linear segment is rounded directly.
  function automatic logic [7:0] enc_entry(input int unsigned i);
    logic [255:0] p;
    logic [255:0] n5;
    logic [255:0] thr;
    logic [7:0]   k;
    logic [7:0]   cand;
    k = '0;
    if (64'(i) * 64'd10000000 <= 64'd31308 * ENC_N) begin
      k = 8'((64'd32946 * 64'(i) + 64'd5 * ENC_N) / LIN_DIV);
    end else begin
      p  = big_pow(256'(i), 5) * big_pow(256'd10761, 12);
      n5 = big_pow(256'(ENC_N), 5);
      for (int b = 7; b >= 0; b--) begin
        cand = k | (8'd1 << b);
        thr  = n5 * big_pow(256'(16'd40 * 16'(cand) + 16'd541), 12);
        if (p >= thr) begin
          k = cand;
        end
      end
    end
    return k;
  endfunction

  logic [7:0] rom_w [0:ROM_DEPTH-1];

  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
    localparam logic [7:0] ENTRY = enc_entry(gi);
    assign rom_w[gi] = ENTRY;
  end

  logic [rdcp_pkg::Q15_W-1:0] floor_sat;
  logic [rdcp_pkg::Q15_W-1:0] lifted;
  logic [PROD_W-1:0]          prod_r;
  logic [IDX_W-1:0]           idx_r;
  logic [7:0]                 enc_r;

  assign floor_sat = (floor_level > rdcp_pkg::ONE_Q15) ? rdcp_pkg::ONE_Q15 : floor_level;
  assign lifted    = floor_sat + rdcp_pkg::Q15_W'((prod_r + PROD_W'(16384)) >> 15);

  always_ff @(posedge clk) begin
    if (en.d) begin
      prod_r <= PROD_W'(rdcp_pkg::ONE_Q15 - floor_sat) * PROD_W'(value);
    end
    if (en.e) begin
      idx_r <= lifted[rdcp_pkg::Q15_W-1:LIFT_SH];
    end
    if (en.f) begin
      enc_r <= passthrough ? {code, code[rdcp_pkg::CH_BITS-1:rdcp_pkg::CH_BITS-3]}
                           : rom_w[idx_r];
    end
  end

  assign enc = enc_r;

endmodule

@@ design/rgb555_display_color_pipeline_unit.sv @@
// ----------------------------------------------------------------------------
// RGB555 display colour pipeline
// Converts 15-bit pixels to 8-bit RGB through decode table, matrix, black
// floor and sRGB encode, or by bit replication in passthrough mode.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one item per transfer: a
// pixel to convert (in_command low) or a decode table write (in_command high).
// A table write updates the entry at its transfer and produces no result.
// Each pixel produces one transfer on the output channel (out_valid,
// out_stall) with the three 8-bit channels.
// The pipeline has six register stages: table read, products, sum and clamp,
// floor product, lift and index, encode ROM read. One pixel is accepted per
// cycle while in_stall is low. When the output is stalled, each stage holds
// and empty stages close up, so input is stalled only when all six stages
// hold pixels and the output stalls. Registers are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while the pipeline
// is empty, as the block itself does not enforce it. Reset empties the
// pipeline and restores the register defaults (passthrough on, identity
// matrix, no floor). The decode table is not cleared and must be loaded
// before pixels are sent in display mode.
// ----------------------------------------------------------------------------
module rgb555_display_color_pipeline_unit #(
  parameter int unsigned COEF_FRAC_BITS    = 14,
  parameter int unsigned ENCODE_INDEX_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rdcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_command,
  input  logic [rdcp_pkg::PIXEL_W-1:0]       in_pixel,
  input  logic [rdcp_pkg::CH_BITS-1:0]       in_table_index,
  input  logic [rdcp_pkg::Q15_W-1:0]         in_table_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_red_out,
  output logic [7:0]                         out_green_out,
  output logic [7:0]                         out_blue_out
);

  localparam int unsigned STAGES = 6;
  localparam int unsigned PIX_W  = rdcp_pkg::NUM_CH * rdcp_pkg::CH_BITS;

  rdcp_pkg::pipe_en_t en;

  logic [STAGES-1:0] vld_r;
  logic [PIX_W-1:0]  pix_r [0:STAGES-2];
  logic              in_xfer;

  logic                                                passthrough_r;
  logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::ROW_W-1:0]     row_r;
  logic [rdcp_pkg::Q15_W-1:0]                          floor_r;

  logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::CH_BITS-1:0]   codes;
  logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::Q15_W-1:0]     lin;
  logic [rdcp_pkg::NUM_CH-1:0][rdcp_pkg::Q15_W-1:0]     mat_value;
  logic [rdcp_pkg::NUM_CH-1:0][7:0]                    enc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passthrough_r <= 1'b1;
      row_r[0]      <= rdcp_pkg::ROW_W'(54'd16384);
      row_r[1]      <= rdcp_pkg::ROW_W'(54'd4294967296);
      row_r[2]      <= rdcp_pkg::ROW_W'(54'd1125899906842624);
      floor_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rdcp_pkg::REG_PASSTHROUGH: passthrough_r <= cfg_data[0];
        rdcp_pkg::REG_ROW_RED:     row_r[0]      <= cfg_data[rdcp_pkg::ROW_W-1:0];
        rdcp_pkg::REG_ROW_GREEN:   row_r[1]      <= cfg_data[rdcp_pkg::ROW_W-1:0];
        rdcp_pkg::REG_ROW_BLUE:    row_r[2]      <= cfg_data[rdcp_pkg::ROW_W-1:0];
        rdcp_pkg::REG_FLOOR_LIFT:  floor_r       <= cfg_data[rdcp_pkg::Q15_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    en.f = !vld_r[5] || !out_stall;
    en.e = !vld_r[4] || en.f;
    en.d = !vld_r[3] || en.e;
    en.c = !vld_r[2] || en.d;
    en.b = !vld_r[1] || en.c;
    en.a = !vld_r[0] || en.b;
  end

  assign in_stall = !en.a;
  assign in_xfer  = in_valid && en.a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en.a) begin
        vld_r[0] <= in_valid && !in_command;
      end
      if (en.b) begin
        vld_r[1] <= vld_r[0];
      end
      if (en.c) begin
        vld_r[2] <= vld_r[1];
      end
      if (en.d) begin
        vld_r[3] <= vld_r[2];
      end
      if (en.e) begin
        vld_r[4] <= vld_r[3];
      end
      if (en.f) begin
        vld_r[5] <= vld_r[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      pix_r[0] <= in_pixel[PIX_W-1:0];
    end
    if (en.b) begin
      pix_r[1] <= pix_r[0];
    end
    if (en.c) begin
      pix_r[2] <= pix_r[1];
    end
    if (en.d) begin
      pix_r[3] <= pix_r[2];
    end
    if (en.e) begin
      pix_r[4] <= pix_r[3];
    end
  end

  for (genvar gj = 0; gj < rdcp_pkg::NUM_CH; gj++) begin : g_codes
    assign codes[gj] = in_pixel[gj*rdcp_pkg::CH_BITS +: rdcp_pkg::CH_BITS];
  end

  rdcp_decode u_decode (
    .clk      (clk),
    .en       (en),
    .wr_en    (in_xfer && in_command),
    .wr_index (in_table_index),
    .wr_value (in_table_value),
    .codes    (codes),
    .lin      (lin)
  );

  for (genvar gj = 0; gj < rdcp_pkg::NUM_CH; gj++) begin : g_chan
    rdcp_matrix #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_matrix (
      .clk   (clk),
      .en    (en),
      .row   (row_r[gj]),
      .lin   (lin),
      .value (mat_value[gj])
    );

    rdcp_encode #(
      .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_encode (
      .clk         (clk),
      .en          (en),
      .passthrough (passthrough_r),
      .floor_level (floor_r),
      .value       (mat_value[gj]),
      .code        (pix_r[STAGES-2][gj*rdcp_pkg::CH_BITS +: rdcp_pkg::CH_BITS]),
      .enc         (enc[gj])
    );
  end

  assign out_valid     = vld_r[STAGES-1];
  assign out_red_out   = enc[0];
  assign out_green_out = enc[1];
  assign out_blue_out  = enc[2];

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command) |=> !vld_r[0])
    else $error("table load entered the pipeline as a pixel");

  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_command) |=> vld_r[0])
    else $error("accepted pixel was lost at the first stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld_r[0] && out_stall))
    else $error("input stalled without a full first stage and output stall");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !en.e) |=> vld_r[4])
    else $error("stalled stage lost its item");

endmodule

@@ tb/tb_rgb555_display_color_pipeline_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RGB555 display colour pipeline
// Sends pixel and decode table transfers with random gaps while the output
// stalls at random. Every result is checked channel by channel against a
// predictor that models bit replication, table decode, the signed matrix,
// clamping, the black floor lift and an exact integer sRGB encode table.
// Directed tests cover field extremes, saturation, the floor and unused
// register indices. Random phases then vary every register.
// ----------------------------------------------------------------------------
module tb_rgb555_display_color_pipeline_unit;

  localparam int unsigned FRAC_BITS    = 14;
  localparam int unsigned IDX_BITS     = 12;
  localparam int unsigned ENC_N        = 1 << IDX_BITS;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_PHASES  = 9;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam logic [rdcp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [rdcp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            cfg_wr_en      = 1'b0;
  logic [rdcp_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [rdcp_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
  logic                            in_valid       = 1'b0;
  logic                            in_stall;
  logic                            in_command     = 1'b0;
  logic [rdcp_pkg::PIXEL_W-1:0]    in_pixel       = '0;
  logic [rdcp_pkg::CH_BITS-1:0]    in_table_index = '0;
  logic [rdcp_pkg::Q15_W-1:0]      in_table_value = '0;
  logic                            out_valid;
  logic                            out_stall      = 1'b0;
  logic [7:0]                      out_red_out;
  logic [7:0]                      out_green_out;
  logic [7:0]                      out_blue_out;

  logic                            cfg_passthrough;
  logic [rdcp_pkg::ROW_W-1:0]      cfg_row [rdcp_pkg::NUM_CH];
  logic [rdcp_pkg::Q15_W-1:0]      cfg_floor;
  logic [rdcp_pkg::Q15_W-1:0]      lin_lut [32];
  logic [7:0]                      enc_rom [0:ENC_N];
  rgb_t                            expected_q [$];
  int unsigned                     err_count   = 0;
  int unsigned                     cycle_count = 0;
  bit                              calm        = 1'b0;

  rgb555_display_color_pipeline_unit #(
    .COEF_FRAC_BITS    (FRAC_BITS),
    .ENCODE_INDEX_BITS (IDX_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_pixel       (in_pixel),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out)
  );

  always #5 clk = ~clk;

  // Code k is reached once i^5 * 10761^12 >= n^5 * (40k + 541)^12.
  function automatic void build_encode_rom();
    logic [255:0] thr [1:255];
    logic [255:0] p;
    int unsigned  i;
    int unsigned  k;
    for (k = 1; k < 256; k++) begin
      thr[k] = 256'd1;
      repeat (5) thr[k] = thr[k] * 256'(ENC_N);
      repeat (12) thr[k] = thr[k] * 256'(40 * k + 541);
    end
    k = 0;
    for (i = 0; i <= ENC_N; i++) begin
      if (longint'(i) * 10000000 <= longint'(31308) * longint'(ENC_N)) begin
        enc_rom[i] = 8'((longint'(32946) * longint'(i) + 5 * longint'(ENC_N))
                        / (10 * longint'(ENC_N)));
      end else begin
        p = 256'(i);
        repeat (4) p = p * 256'(i);
        repeat (12) p = p * 256'(10761);
        while (k < 255 && p >= thr[k + 1]) k++;
        enc_rom[i] = 8'(k);
      end
    end
  endfunction

  function automatic logic [7:0] encode_channel(input logic [rdcp_pkg::ROW_W-1:0] row,
                                                input logic [3*rdcp_pkg::Q15_W-1:0] lin);
    logic [rdcp_pkg::COEF_W-1:0] raw;
    longint                      sum;
    longint                      c;
    longint                      v;
    longint                      f;
    longint                      lifted;
    int unsigned                 j;
    sum = 0;
    for (j = 0; j < rdcp_pkg::NUM_CH; j++) begin
      raw = row[rdcp_pkg::COEF_W*j +: rdcp_pkg::COEF_W];
      c   = longint'(raw);
      if (raw[rdcp_pkg::COEF_W-1]) c = c - (longint'(1) <<< rdcp_pkg::COEF_W);
      sum = sum + c * longint'(lin[rdcp_pkg::Q15_W*j +: rdcp_pkg::Q15_W]);
    end
    if (sum <= 0) begin
      v = 0;
    end else begin
      v = (sum + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (v > longint'(rdcp_pkg::ONE_Q15)) v = longint'(rdcp_pkg::ONE_Q15);
    end
    f = longint'((cfg_floor > rdcp_pkg::ONE_Q15) ? rdcp_pkg::ONE_Q15 : cfg_floor);
    lifted = f + (((longint'(rdcp_pkg::ONE_Q15) - f) * v + 16384) >>> 15);
    return enc_rom[lifted >>> (15 - IDX_BITS)];
  endfunction

  function automatic rgb_t expected_rgb(input logic [rdcp_pkg::PIXEL_W-1:0] px);
    logic [rdcp_pkg::CH_BITS-1:0] cr;
    logic [rdcp_pkg::CH_BITS-1:0] cg;
    logic [rdcp_pkg::CH_BITS-1:0] cb;
    logic [3*rdcp_pkg::Q15_W-1:0] lin;
    rgb_t                         res;
    cr = px[4:0];
    cg = px[9:5];
    cb = px[14:10];
    if (cfg_passthrough) begin
      res.r = {cr, cr[4:2]};
      res.g = {cg, cg[4:2]};
      res.b = {cb, cb[4:2]};
    end else begin
      lin   = {lin_lut[cb], lin_lut[cg], lin_lut[cr]};
      res.r = encode_channel(cfg_row[0], lin);
      res.g = encode_channel(cfg_row[1], lin);
      res.b = encode_channel(cfg_row[2], lin);
    end
    return res;
  endfunction

  function automatic logic [rdcp_pkg::ROW_W-1:0] pack_row(
    input logic [rdcp_pkg::COEF_W-1:0] c0,
    input logic [rdcp_pkg::COEF_W-1:0] c1,
    input logic [rdcp_pkg::COEF_W-1:0] c2
  );
    return {c2, c1, c0};
  endfunction

  function automatic logic [rdcp_pkg::COEF_W-1:0] random_coef();
    if ($urandom_range(3) == 0) return rdcp_pkg::COEF_W'($urandom);
    return rdcp_pkg::COEF_W'($urandom_range(0, 28672) - 6144);
  endfunction

  function automatic logic [rdcp_pkg::Q15_W-1:0] random_level();
    if ($urandom_range(9) < 7) return rdcp_pkg::Q15_W'($urandom_range(0, 32768));
    return rdcp_pkg::Q15_W'($urandom);
  endfunction

  task automatic send_item(input logic cmd, input logic [rdcp_pkg::PIXEL_W-1:0] px,
                           input logic [rdcp_pkg::CH_BITS-1:0] idx,
                           input logic [rdcp_pkg::Q15_W-1:0] val);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 3) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_pixel       <= px;
    in_table_index <= idx;
    in_table_value <= val;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_TABLE) begin
      lin_lut[idx] = (val > rdcp_pkg::ONE_Q15) ? rdcp_pkg::ONE_Q15 : val;
    end else begin
      expected_q.push_back(expected_rgb(px));
    end
  endtask

  task automatic send_pixel(input logic [rdcp_pkg::PIXEL_W-1:0] px);
    send_item(CMD_PIXEL, px, rdcp_pkg::CH_BITS'($urandom), rdcp_pkg::Q15_W'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rdcp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rdcp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      rdcp_pkg::REG_PASSTHROUGH: cfg_passthrough = data[0];
      rdcp_pkg::REG_ROW_RED:     cfg_row[0] = data[rdcp_pkg::ROW_W-1:0];
      rdcp_pkg::REG_ROW_GREEN:   cfg_row[1] = data[rdcp_pkg::ROW_W-1:0];
      rdcp_pkg::REG_ROW_BLUE:    cfg_row[2] = data[rdcp_pkg::ROW_W-1:0];
      rdcp_pkg::REG_FLOOR_LIFT:  cfg_floor = data[rdcp_pkg::Q15_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_identity();
    write_reg(rdcp_pkg::REG_ROW_RED,   pack_row(rdcp_pkg::COEF_W'(16384), '0, '0));
    write_reg(rdcp_pkg::REG_ROW_GREEN, pack_row('0, rdcp_pkg::COEF_W'(16384), '0));
    write_reg(rdcp_pkg::REG_ROW_BLUE,  pack_row('0, '0, rdcp_pkg::COEF_W'(16384)));
  endtask

  task automatic send_edge_pixels();
    send_pixel(16'h0000);
    send_pixel(16'h7FFF);
    send_pixel(16'hFFFF);
    send_pixel(16'($urandom));
  endtask

  task automatic test_passthrough_reset();
    send_edge_pixels();
    send_pixel(16'h8000);
    send_pixel(16'h001F);
    send_pixel(16'h03E0);
    send_pixel(16'h7C00);
    send_pixel(16'h5555);
    send_pixel(16'h2AAA);
  endtask

  task automatic test_table_load();
    int unsigned                i;
    logic [rdcp_pkg::Q15_W-1:0] val;
    for (i = 0; i < 32; i++) begin
      case (i)
        0:       val = '0;
        29:      val = rdcp_pkg::ONE_Q15 + 16'd1;
        30:      val = '1;
        31:      val = rdcp_pkg::ONE_Q15;
        default: val = rdcp_pkg::Q15_W'(i * i * 34);
      endcase
      send_item(CMD_TABLE, 16'($urandom), rdcp_pkg::CH_BITS'(i), val);
      if (i % 8 == 7) send_pixel(16'($urandom));
    end
  endtask

  task automatic test_identity_display();
    drain();
    write_reg(rdcp_pkg::REG_PASSTHROUGH, rdcp_pkg::CFG_DATA_W'($urandom) << 1);
    write_identity();
    write_reg(rdcp_pkg::REG_FLOOR_LIFT, '0);
    send_edge_pixels();
    send_pixel(16'h001F);
    send_pixel(16'h03E0);
    send_pixel(16'h7C00);
    send_pixel(16'h7BDE);
  endtask

  task automatic test_matrix_extremes();
    drain();
    write_reg(rdcp_pkg::REG_ROW_RED,   pack_row(18'h1FFFF, 18'h1FFFF, 18'h1FFFF));
    write_reg(rdcp_pkg::REG_ROW_GREEN, pack_row(18'h20000, 18'h20000, 18'h20000));
    write_reg(rdcp_pkg::REG_ROW_BLUE,
              pack_row(rdcp_pkg::COEF_W'(16384), -rdcp_pkg::COEF_W'(16384), '0));
    send_edge_pixels();
    send_pixel(16'h03FF);
    drain();
    write_reg(rdcp_pkg::REG_ROW_RED,
              pack_row(rdcp_pkg::COEF_W'(19661), -rdcp_pkg::COEF_W'(3277), '0));
    write_reg(rdcp_pkg::REG_ROW_GREEN,
              pack_row(-rdcp_pkg::COEF_W'(1147), rdcp_pkg::COEF_W'(17531), '0));
    write_reg(rdcp_pkg::REG_ROW_BLUE,
              pack_row('0, -rdcp_pkg::COEF_W'(1716), rdcp_pkg::COEF_W'(18100)));
    send_edge_pixels();
  endtask

  task automatic test_floor_lift();
    logic [rdcp_pkg::Q15_W-1:0] levels [4];
    int unsigned                i;
    levels = '{16'd16384, rdcp_pkg::ONE_Q15, 16'hFFFF, 16'd1};
    drain();
    write_identity();
    for (i = 0; i < 4; i++) begin
      drain();
      write_reg(rdcp_pkg::REG_FLOOR_LIFT, {38'($urandom), levels[i]});
      send_pixel(16'h0000);
      send_pixel(16'h7FFF);
      send_pixel(16'($urandom));
    end
  endtask

  task automatic test_unknown_register();
    int unsigned i;
    drain();
    for (i = 32'(REG_SPARE_LO); i <= 32'(REG_SPARE_HI); i++) begin
      write_reg(rdcp_pkg::CFG_IDX_W'(i), rdcp_pkg::CFG_DATA_W'({$urandom, $urandom}));
    end
    send_edge_pixels();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      write_reg(rdcp_pkg::REG_PASSTHROUGH, (rdcp_pkg::CFG_DATA_W'($urandom) << 1)
                                           | rdcp_pkg::CFG_DATA_W'(phase == 2));
      write_reg(rdcp_pkg::REG_ROW_RED,
                pack_row(random_coef(), random_coef(), random_coef()));
      write_reg(rdcp_pkg::REG_ROW_GREEN,
                pack_row(random_coef(), random_coef(), random_coef()));
      write_reg(rdcp_pkg::REG_ROW_BLUE,
                pack_row(random_coef(), random_coef(), random_coef()));
      case (phase)
        5: write_reg(rdcp_pkg::REG_FLOOR_LIFT, rdcp_pkg::CFG_DATA_W'(rdcp_pkg::ONE_Q15));
        6: write_reg(rdcp_pkg::REG_FLOOR_LIFT, '0);
        7: write_reg(rdcp_pkg::REG_FLOOR_LIFT,
                     rdcp_pkg::CFG_DATA_W'(rdcp_pkg::Q15_W'($urandom)));
        default: write_reg(rdcp_pkg::REG_FLOOR_LIFT,
                           rdcp_pkg::CFG_DATA_W'($urandom_range(0, 8192)));
      endcase
      calm = (phase == 4);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) == 0) begin
          send_item(CMD_TABLE, 16'($urandom), rdcp_pkg::CH_BITS'($urandom), random_level());
        end else begin
          send_pixel(16'($urandom));
        end
      end
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    out_stall <= !calm && ($urandom_range(99) < 8);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_rgb555_display_color_pipeline_unit: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    rgb_t got;
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_red_out, out_green_out, out_blue_out};
      if (expected_q.size() == 0) begin
        if (err_count < 10) begin
          $display("unexpected transfer: r=%0d g=%0d b=%0d", got.r, got.g, got.b);
        end
        err_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
          if (err_count < 10) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.r, want.g, want.b, got.r, got.g, got.b);
          end
          err_count++;
        end
      end
    end
  end

  initial begin
    build_encode_rom();
    cfg_passthrough = 1'b1;
    cfg_row[0]      = pack_row(rdcp_pkg::COEF_W'(16384), '0, '0);
    cfg_row[1]      = pack_row('0, rdcp_pkg::COEF_W'(16384), '0);
    cfg_row[2]      = pack_row('0, '0, rdcp_pkg::COEF_W'(16384));
    cfg_floor       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_passthrough_reset();
    test_table_load();
    test_identity_display();
    test_matrix_extremes();
    test_floor_lift();
    test_unknown_register();
    test_random_traffic();
    drain();
    if (err_count == 0) begin
      $display("tb_rgb555_display_color_pipeline_unit: done, clean");
    end else begin
      $display("tb_rgb555_display_color_pipeline_unit: done, errors");
    end
    $finish;
  end

endmodule
